### hw/rtl/qlu_pkg.sv
// Shared types and constants for the quoted literal unescape core.
// No dependencies; imported by every module of the block.
package qlu_pkg;

  localparam logic [7:0] CH_DQ  = 8'h22;  // double quote
  localparam logic [7:0] CH_SQ  = 8'h27;  // single quote
  localparam logic [7:0] CH_BS  = 8'h5C;  // backslash
  localparam logic [7:0] CH_NL  = 8'h0A;  // newline
  localparam logic [7:0] CH_TAB = 8'h09;  // horizontal tab
  localparam logic [7:0] CH_LN  = 8'h6E;  // letter n
  localparam logic [7:0] CH_LT  = 8'h74;  // letter t
  localparam logic [7:0] CH_LX  = 8'h78;  // letter x

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EOL     = 3'd1,
    ST_INC_ESC = 3'd2,
    ST_BAD_ESC = 3'd3,
    ST_BAD_HEX = 3'd4,
    ST_INC_HEX = 3'd5,
    ST_NOT_LIT = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HEX1  = 2'd2,
    PH_HEX2  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ESC_CHAR = 2'd0,
    ESC_HEX  = 2'd1,
    ESC_BAD  = 2'd2
  } esc_t;

  // One classified source byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] src;
    logic       ends;
    logic       is_dq;
    logic       is_sq;
    logic       is_bs;
    logic       is_nl;
    logic       hex_ok;
    logic [3:0] hex_val;
    esc_t       esc_kind;
    logic [7:0] esc_char;
  } item_t;

endpackage

### hw/rtl/qlu_front.sv
// Front end of the quoted literal unescape core: accepts source bytes and
// classifies them for the back end. Depends on qlu_pkg.
module qlu_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     source_byte,
  input  logic           input_ends,
  input  logic           q_full,
  output logic           q_push,
  output qlu_pkg::item_t q_item
);
  import qlu_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item          = '0;
    q_item.src      = source_byte;
    q_item.ends     = input_ends;
    q_item.is_dq    = (source_byte == CH_DQ);
    q_item.is_sq    = (source_byte == CH_SQ);
    q_item.is_bs    = (source_byte == CH_BS);
    q_item.is_nl    = (source_byte == CH_NL);

    // Hex digit value; the low nibble of the offset form is the digit.
    if (source_byte >= 8'h30 && source_byte <= 8'h39) begin
      q_item.hex_ok  = 1'b1;
      q_item.hex_val = source_byte[3:0];
    end else if ((source_byte >= 8'h61 && source_byte <= 8'h66) ||
                 (source_byte >= 8'h41 && source_byte <= 8'h46)) begin
      q_item.hex_ok  = 1'b1;
      q_item.hex_val = 4'(source_byte[3:0] + 4'd9);
    end

    // Meaning of this byte if it follows a backslash.
    unique case (source_byte)
      CH_BS:  begin q_item.esc_kind = ESC_CHAR; q_item.esc_char = CH_BS;  end
      CH_LN:  begin q_item.esc_kind = ESC_CHAR; q_item.esc_char = CH_NL;  end
      CH_LT:  begin q_item.esc_kind = ESC_CHAR; q_item.esc_char = CH_TAB; end
      CH_DQ:  begin q_item.esc_kind = ESC_CHAR; q_item.esc_char = CH_DQ;  end
      CH_SQ:  begin q_item.esc_kind = ESC_CHAR; q_item.esc_char = CH_SQ;  end
      CH_LX:  begin q_item.esc_kind = ESC_HEX;  q_item.esc_char = 8'h00;  end
      default: begin q_item.esc_kind = ESC_BAD; q_item.esc_char = 8'h00;  end
    endcase
  end

endmodule

### hw/rtl/qlu_queue.sv
// Short first-in first-out queue of classified bytes between the front and
// the back of the quoted literal unescape core. Depends on qlu_pkg.
module qlu_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qlu_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output qlu_pkg::item_t head
);
  import qlu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count exceeds depth");
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CW'($past(count) + 1'b1))
    else $error("queue count did not grow on push");
  a_count_shrink: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == CW'($past(count) - 1'b1))
    else $error("queue count did not shrink on pop");
`endif

endmodule

### hw/rtl/qlu_back.sv
// Back end of the quoted literal unescape core: literal state, escape
// decoding and the output register. Depends on qlu_pkg.
module qlu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  qlu_pkg::item_t    q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        decoded_byte,
  output logic              is_end,
  output qlu_pkg::status_t  status,
  output logic              quote_style
);
  import qlu_pkg::*;

  logic       in_literal, in_literal_next;
  logic       quote_kind, quote_kind_next;
  logic       skip_next, skip_next_next;
  phase_t     phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       first_digit_bad, first_digit_bad_next;
  status_t    latched_error, latched_error_next;

  logic       emit, emit_end, emit_style;
  logic [7:0] emit_byte;
  status_t    emit_status;
  logic       load;

  // The output register takes a new word whenever it is empty or being read.
  assign load  = !out_valid || out_ready;
  assign q_pop = q_valid && load;

  always_comb begin
    logic got;
    logic [7:0] ch;
    logic close_quote;
    logic pend;

    in_literal_next      = in_literal;
    quote_kind_next      = quote_kind;
    skip_next_next       = skip_next;
    phase_next           = phase;
    high_nibble_next     = high_nibble;
    first_digit_bad_next = first_digit_bad;
    latched_error_next   = latched_error;
    emit        = 1'b0;
    emit_end    = 1'b0;
    emit_byte   = 8'h00;
    emit_status = ST_OK;
    emit_style  = quote_kind;
    got         = 1'b0;
    ch          = 8'h00;
    close_quote = 1'b0;
    pend        = 1'b0;

    if (q_pop) begin
      if (!in_literal) begin
        if (q_item.is_dq || q_item.is_sq) begin
          in_literal_next      = !q_item.ends;
          quote_kind_next      = q_item.is_sq;
          skip_next_next       = 1'b0;
          phase_next           = PH_PLAIN;
          high_nibble_next     = 4'h0;
          first_digit_bad_next = 1'b0;
          latched_error_next   = ST_OK;
          if (q_item.ends) begin
            emit        = 1'b1;
            emit_end    = 1'b1;
            emit_status = ST_EOL;
            emit_style  = q_item.is_sq;
          end
        end else begin
          emit        = 1'b1;
          emit_end    = 1'b1;
          emit_status = ST_NOT_LIT;
          emit_style  = 1'b0;
        end
      end else begin
        close_quote = !skip_next && !q_item.is_bs &&
                      (quote_kind ? q_item.is_sq : q_item.is_dq);
        if (q_item.is_nl || close_quote) begin
          emit     = 1'b1;
          emit_end = 1'b1;
          if (q_item.is_nl) begin
            emit_status = skip_next ? ST_INC_ESC : ST_EOL;
          end else if (latched_error != ST_OK) begin
            emit_status = latched_error;
          end else begin
            unique case (phase)
              PH_HEX1: emit_status = ST_INC_HEX;
              PH_HEX2: emit_status = ST_BAD_HEX;
              PH_ESC:  emit_status = ST_INC_ESC;
              default: emit_status = ST_OK;
            endcase
          end
        end else begin
          pend           = !skip_next && q_item.is_bs;
          skip_next_next = pend;
          if (latched_error == ST_OK) begin
            unique case (phase)
              PH_PLAIN: begin
                if (q_item.is_bs) begin
                  phase_next = PH_ESC;
                end else begin
                  got = 1'b1;
                  ch  = q_item.src;
                end
              end
              PH_ESC: begin
                phase_next = PH_PLAIN;
                unique case (q_item.esc_kind)
                  ESC_CHAR: begin
                    got = 1'b1;
                    ch  = q_item.esc_char;
                  end
                  ESC_HEX: phase_next = PH_HEX1;
                  default: latched_error_next = ST_BAD_ESC;
                endcase
              end
              PH_HEX1: begin
                first_digit_bad_next = !q_item.hex_ok;
                high_nibble_next     = q_item.hex_ok ? q_item.hex_val : 4'h0;
                phase_next           = PH_HEX2;
              end
              default: begin
                phase_next = PH_PLAIN;
                if (first_digit_bad || !q_item.hex_ok) begin
                  latched_error_next = ST_BAD_HEX;
                end else begin
                  got = 1'b1;
                  ch  = {high_nibble, q_item.hex_val};
                end
              end
            endcase
          end
          if (q_item.ends) begin
            emit        = 1'b1;
            emit_end    = 1'b1;
            emit_status = pend ? ST_INC_ESC : ST_EOL;
          end else if (got) begin
            emit      = 1'b1;
            emit_byte = ch;
          end
        end
        // Every end result inside a literal returns the decoder to idle.
        if (emit_end) begin
          in_literal_next      = 1'b0;
          skip_next_next       = 1'b0;
          phase_next           = PH_PLAIN;
          high_nibble_next     = 4'h0;
          first_digit_bad_next = 1'b0;
          latched_error_next   = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_literal      <= 1'b0;
      quote_kind      <= 1'b0;
      skip_next       <= 1'b0;
      phase           <= PH_PLAIN;
      high_nibble     <= 4'h0;
      first_digit_bad <= 1'b0;
      latched_error   <= ST_OK;
      out_valid       <= 1'b0;
    end else begin
      in_literal      <= in_literal_next;
      quote_kind      <= quote_kind_next;
      skip_next       <= skip_next_next;
      phase           <= phase_next;
      high_nibble     <= high_nibble_next;
      first_digit_bad <= first_digit_bad_next;
      latched_error   <= latched_error_next;
      if (load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      decoded_byte <= emit_byte;
      is_end       <= emit_end;
      status       <= emit_status;
      quote_style  <= emit_style;
    end
  end

`ifndef SYNTHESIS
  a_char_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_end |-> status == ST_OK)
    else $error("character word carries a nonzero status");
  a_not_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOT_LIT |-> is_end && !quote_style && !$past(in_literal))
    else $error("not-literal word is malformed");
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    emit && emit_end |=> !in_literal && latched_error == ST_OK)
    else $error("decoder not idle after an end word");
`endif

endmodule

### hw/rtl/quoted_literal_unescape_core.sv
// Top level of the quoted literal unescape core.
// Depends on qlu_pkg, qlu_front, qlu_queue and qlu_back.
//
// Usage: source text enters one byte per word on the input channel
// (source_byte, with input_ends set on the last byte of the text). While
// idle, a double or single quote opens a literal; any other byte yields an
// end word with the not-literal status. Inside a literal each decoded
// character leaves as one word with is_end low, and the literal closes with
// one word with is_end high that carries the status and the quote style.
// On an error status the receiver should discard the characters it got.
// The front classifies each byte and pushes it into a short queue of
// QUEUE_DEPTH entries; the back runs the literal decoder and owns the
// output register. Accepted bytes pass through the queue into the output
// register. Without receiver stalls both channels sustain one word per cycle.
// When the receiver stalls, the output register holds its word, the back
// stops draining the queue, and in_ready drops only once the queue is full.
// Reset (synchronous, active high) empties the queue, drops out_valid and
// returns the decoder to idle outside any literal.
module quoted_literal_unescape_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] source_byte,
  input  logic       input_ends,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] decoded_byte,
  output logic       is_end,
  output logic [2:0] status,
  output logic       quote_style
);
  import qlu_pkg::*;

  item_t   push_item;
  item_t   head_item;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  status_t status_w;

  // Classification of incoming bytes.
  qlu_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .source_byte (source_byte),
    .input_ends  (input_ends),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  // Decoupling queue so the front keeps taking bytes while the back stalls.
  qlu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_item)
  );

  // Literal decoder and output register.
  qlu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .decoded_byte (decoded_byte),
    .is_end       (is_end),
    .status       (status_w),
    .quote_style  (quote_style)
  );

  assign status = status_w;

endmodule

### verif/tb_top.sv
// Self-checking testbench for quoted_literal_unescape_core: directed table, then random literals.
// Depends on qlu_pkg for character codes and the status and phase enums.
// A built-in unescape predictor supplies the expected word, if any, for each accepted untyped source byte.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qlu_pkg::*;

  localparam int RAND_WORDS   = 1750;
  localparam int HOLD_AT      = 500;   // accepted words before the long receiver hold-off
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_AT     = 900;   // random words before the sender waits for a full drain
  localparam int TAIL_CYCLES  = 16;
  localparam int STALL_LIMIT  = 3000;  // cycles without any accepted word before giving up

  // One expected or observed result word.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    status_t    st;
    logic       style;
  } lit_word_t;

  // A directed stimulus row. Rows with typed set carry their expected word;
  // the others are checked against the predictor.
  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       typed;
    lit_word_t  w;
  } dir_row_t;

  localparam lit_word_t NO_WORD = '0;
  localparam int DIR_N = 29;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // Bytes outside a literal, at both extremes of the byte range.
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, ST_NOT_LIT, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, ST_NOT_LIT, 1'b0}},
    // An opening quote that is also the last byte of the input.
    '{CH_DQ, 1'b1, 1'b1, '{8'h00, 1'b1, ST_EOL, 1'b0}},
    '{CH_SQ, 1'b1, 1'b1, '{8'h00, 1'b1, ST_EOL, 1'b1}},
    // "\xFf\q" : hex escape decodes to 0xFF, then an invalid escape is latched.
    '{CH_DQ, 1'b0, 1'b0, NO_WORD},
    '{CH_BS, 1'b0, 1'b0, NO_WORD},
    '{CH_LX, 1'b0, 1'b0, NO_WORD},
    '{"F",   1'b0, 1'b0, NO_WORD},
    '{"f",   1'b0, 1'b0, NO_WORD},
    '{CH_BS, 1'b0, 1'b0, NO_WORD},
    '{"q",   1'b0, 1'b0, NO_WORD},
    '{CH_DQ, 1'b0, 1'b1, '{8'h00, 1'b1, ST_BAD_ESC, 1'b0}},
    // '\x7' : closing quote after a single hex digit.
    '{CH_SQ, 1'b0, 1'b0, NO_WORD},
    '{CH_BS, 1'b0, 1'b0, NO_WORD},
    '{CH_LX, 1'b0, 1'b0, NO_WORD},
    '{"7",   1'b0, 1'b0, NO_WORD},
    '{CH_SQ, 1'b0, 1'b1, '{8'h00, 1'b1, ST_BAD_HEX, 1'b1}},
    // "\x" : closing quote before any hex digit.
    '{CH_DQ, 1'b0, 1'b0, NO_WORD},
    '{CH_BS, 1'b0, 1'b0, NO_WORD},
    '{CH_LX, 1'b0, 1'b0, NO_WORD},
    '{CH_DQ, 1'b0, 1'b1, '{8'h00, 1'b1, ST_INC_HEX, 1'b0}},
    // Newline right after a backslash, then a plain newline.
    '{CH_DQ, 1'b0, 1'b0, NO_WORD},
    '{"A",   1'b0, 1'b0, NO_WORD},
    '{CH_BS, 1'b0, 1'b0, NO_WORD},
    '{CH_NL, 1'b0, 1'b1, '{8'h00, 1'b1, ST_INC_ESC, 1'b0}},
    '{CH_SQ, 1'b0, 1'b0, NO_WORD},
    '{CH_NL, 1'b0, 1'b1, '{8'h00, 1'b1, ST_EOL, 1'b1}},
    // End of input on a pending backslash.
    '{CH_DQ, 1'b0, 1'b0, NO_WORD},
    '{CH_BS, 1'b1, 1'b1, '{8'h00, 1'b1, ST_INC_ESC, 1'b0}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] source_byte = 8'h00;
  logic       input_ends = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] decoded_byte;
  logic       is_end;
  logic [2:0] status;
  logic       quote_style;

  // Typed expectation travelling with the driven word, so that it is stable
  // at the edge where the word is accepted.
  logic       drv_typed = 1'b0;
  lit_word_t  drv_word = '0;

  always #5 clk = ~clk;

  quoted_literal_unescape_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .source_byte (source_byte),
    .input_ends  (input_ends),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .decoded_byte(decoded_byte),
    .is_end      (is_end),
    .status      (status),
    .quote_style (quote_style)
  );

  // ---------------------------------------------------------------------------
  // Unescape predictor. Its state starts at the reset values of the block.
  // ---------------------------------------------------------------------------
  logic       in_lit = 1'b0;
  logic       qkind = 1'b0;
  logic       skip = 1'b0;
  phase_t     phase = PH_PLAIN;
  logic [3:0] hi_nib = 4'h0;
  logic       first_bad = 1'b0;
  status_t    latched = ST_OK;

  lit_word_t  lit_expect [$];
  int         mismatches = 0;
  int         words_in = 0;

  function automatic void leave_literal();
    in_lit    = 1'b0;
    skip      = 1'b0;
    phase     = PH_PLAIN;
    hi_nib    = 4'h0;
    first_bad = 1'b0;
    latched   = ST_OK;
  endfunction

  // Returns {valid, value} of a hex digit character.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // Advances the predictor by one source byte; returns 1 when a word results.
  function automatic bit unescape_step(input logic [7:0] c, input logic e,
                                       output lit_word_t w);
    logic [7:0] qc;
    logic [4:0] hv;
    bit         got;
    w   = '{ch: 8'h00, last: 1'b1, st: ST_OK, style: 1'b0};
    got = 1'b0;
    if (!in_lit) begin
      if (c == CH_DQ || c == CH_SQ) begin
        leave_literal();
        in_lit = 1'b1;
        qkind  = (c == CH_SQ);
        if (e) begin
          leave_literal();
          w.st    = ST_EOL;
          w.style = qkind;
          got     = 1'b1;
        end
      end else begin
        w.st = ST_NOT_LIT;
        got  = 1'b1;
      end
    end else begin
      w.style = qkind;
      qc = qkind ? CH_SQ : CH_DQ;
      if (c == CH_NL) begin
        // A newline always ends the literal and overrides a latched error.
        w.st = skip ? ST_INC_ESC : ST_EOL;
        leave_literal();
        got = 1'b1;
      end else if (!skip && c == qc) begin
        if (latched != ST_OK) w.st = latched;
        else begin
          case (phase)
            PH_HEX1: w.st = ST_INC_HEX;
            PH_HEX2: w.st = ST_BAD_HEX;
            PH_ESC:  w.st = ST_INC_ESC;
            default: w.st = ST_OK;
          endcase
        end
        leave_literal();
        got = 1'b1;
      end else begin
        // A protected byte clears the protection; an unprotected backslash sets it.
        skip = !skip && (c == CH_BS);
        if (latched == ST_OK) begin
          case (phase)
            PH_PLAIN: begin
              if (c == CH_BS) phase = PH_ESC;
              else begin
                w.ch = c;
                got  = 1'b1;
              end
            end
            PH_ESC: begin
              phase = PH_PLAIN;
              got   = 1'b1;
              case (c)
                CH_BS:   w.ch = CH_BS;
                CH_LN:   w.ch = CH_NL;
                CH_LT:   w.ch = CH_TAB;
                CH_DQ:   w.ch = CH_DQ;
                CH_SQ:   w.ch = CH_SQ;
                CH_LX: begin
                  got   = 1'b0;
                  phase = PH_HEX1;
                end
                default: begin
                  got     = 1'b0;
                  latched = ST_BAD_ESC;
                end
              endcase
            end
            PH_HEX1: begin
              hv        = hex_digit(c);
              first_bad = !hv[4];
              hi_nib    = hv[4] ? hv[3:0] : 4'h0;
              phase     = PH_HEX2;
            end
            default: begin
              hv    = hex_digit(c);
              phase = PH_PLAIN;
              if (first_bad || !hv[4]) latched = ST_BAD_HEX;
              else begin
                w.ch = {hi_nib, hv[3:0]};
                got  = 1'b1;
              end
            end
          endcase
          if (got) w.last = 1'b0;
        end
        // The last byte of the input ends an unclosed literal: only the end word
        // comes out, and any character this byte decoded is dropped.
        if (e) begin
          w = '{ch: 8'h00, last: 1'b1, st: (skip ? ST_INC_ESC : ST_EOL), style: qkind};
          leave_literal();
          got = 1'b1;
        end
      end
    end
    return got;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  // Output words are checked before the input word of the same edge is
  // predicted, so the order within the step is fixed by this block alone.
  always @(posedge clk) begin
    lit_word_t w;
    bit        produced;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (lit_expect.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %0h/%0b/%0d/%0b", $time,
                   decoded_byte, is_end, status, quote_style);
          mismatches++;
        end else begin
          w = lit_expect.pop_front();
          check_field("decoded_byte", w.ch, decoded_byte);
          check_field("is_end", {7'd0, w.last}, {7'd0, is_end});
          check_field("status", {5'd0, w.st}, {5'd0, status});
          check_field("quote_style", {7'd0, w.style}, {7'd0, quote_style});
        end
      end
      if (in_valid && in_ready) begin
        words_in++;
        produced = unescape_step(source_byte, input_ends, w);
        if (drv_typed) lit_expect.insert(lit_expect.size(), drv_word);
        else if (produced) lit_expect.insert(lit_expect.size(), w);
      end
    end
  end

  // Watchdog: too many cycles in a row with no word moving on either side.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: segments of random length, each with its own stall pattern,
  // plus one long hold-off that lets the queue fill and stalls the input.
  initial begin : receiver
    int  seg_left;
    int  mode;
    bit  held;
    seg_left = 0;
    mode     = 0;
    held     = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_in >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (seg_left % 3 != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int         burst_left = 0;
  logic [8:0] pend [$];   // {input_ends, source_byte} waiting to be sent

  // Appends one {input_ends, source_byte} pair to the send list.
  function automatic void add_byte(input logic [8:0] v);
    pend.insert(pend.size(), v);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic e, input logic typed,
                           input lit_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid    <= 1'b1;
    source_byte <= b;
    input_ends  <= e;
    drv_typed   <= typed;
    drv_word    <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (lit_expect.size() != 0);
    burst_left = 0;
  endtask

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] qc);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == qc || b == CH_BS || b == CH_NL);
    return b;
  endfunction

  // Queues one literal: mostly plain bytes and well-formed escapes, with
  // broken escapes, stray bytes and every kind of ending mixed in.
  task automatic queue_literal();
    logic [7:0] qc;
    logic [7:0] other;
    int         n;
    int         kind;
    qc    = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
    other = (qc == CH_SQ) ? CH_DQ : CH_SQ;
    // Occasional bytes outside any literal.
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) add_byte({1'($urandom_range(0, 1)), 8'($urandom)});
    end
    add_byte({1'b0, qc});
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) add_byte({1'b0, plain_byte(qc)});
      else if (kind < 50) add_byte({1'b0, other});
      else if (kind < 75) begin
        add_byte({1'b0, CH_BS});
        case ($urandom_range(0, 5))
          0: add_byte({1'b0, CH_BS});
          1: add_byte({1'b0, CH_LN});
          2: add_byte({1'b0, CH_LT});
          3: add_byte({1'b0, CH_DQ});
          4: add_byte({1'b0, CH_SQ});
          default: begin
            add_byte({1'b0, CH_LX});
            add_byte({1'b0, hex_char($urandom_range(0, 15))});
            add_byte({1'b0, hex_char($urandom_range(0, 15))});
          end
        endcase
      end else if (kind < 82) begin
        // Hex escape with arbitrary digit bytes, usually bad.
        add_byte({1'b0, CH_BS});
        add_byte({1'b0, CH_LX});
        add_byte({1'b0, ($urandom_range(0, 1) ? hex_char($urandom_range(0, 15))
                                              : plain_byte(qc))});
        add_byte({1'b0, plain_byte(qc)});
      end else if (kind < 88) begin
        add_byte({1'b0, CH_BS});
        add_byte({1'b0, 8'($urandom)});
      end else if (kind < 94) begin
        // Hex escape cut short after zero or one digit.
        add_byte({1'b0, CH_BS});
        add_byte({1'b0, CH_LX});
        if ($urandom_range(0, 1)) add_byte({1'b0, hex_char($urandom_range(0, 15))});
      end else add_byte({1'b0, 8'($urandom)});
    end
    kind = $urandom_range(0, 99);
    if (kind < 70) add_byte({($urandom_range(0, 4) == 0), qc});
    else if (kind < 80) add_byte({1'b0, CH_NL});
    else if (kind < 88) pend[pend.size() - 1][8] = 1'b1;
    else if (kind < 94) begin
      add_byte({1'b0, CH_BS});
      add_byte({1'b0, CH_NL});
    end else add_byte({1'b1, CH_BS});
  endtask

  initial begin : stimulus
    int         sent;
    logic [8:0] item;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++)
      send_word(DIR_ROWS[i].b, DIR_ROWS[i].e, DIR_ROWS[i].typed, DIR_ROWS[i].w);

    while (sent < RAND_WORDS || pend.size() != 0) begin
      if (pend.size() == 0) queue_literal();
      item = pend.pop_front();
      send_word(item[7:0], item[8], 1'b0, NO_WORD);
      sent++;
      if (sent == DRAIN_AT) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (lit_expect.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, lit_expect.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/qlu_pkg.sv
hw/rtl/qlu_front.sv
hw/rtl/qlu_queue.sv
hw/rtl/qlu_back.sv
hw/rtl/quoted_literal_unescape_core.sv
verif/tb_top.sv
